[sv/tfir_pkg.sv]
// ----------------------------------------------------------------------------
// Time-axis FIR filter package
// Register indexes, field widths, reset values and shared types.
// ----------------------------------------------------------------------------
package tfir_pkg;

   localparam int COEF_W     = 16;
   localparam int TAP_W      = 3;
   localparam int MODE_W     = 2;
   localparam int NUM_COEF   = 5;
   localparam int STEP_W     = 32;
   localparam int FRAC_BITS  = 14;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_TAP_COUNT    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STENCIL_MODE = 3'd1;
   localparam int                    CSR_COEF_BASE    = 2;

   // Stencil modes; the unused code behaves as centered.
   localparam logic [MODE_W-1:0] STENCIL_BACKWARD = 2'd0;
   localparam logic [MODE_W-1:0] STENCIL_FORWARD  = 2'd1;
   localparam logic [MODE_W-1:0] STENCIL_CENTERED = 2'd2;

   localparam logic [TAP_W-1:0]         TAP_COUNT_RESET = 3'd5;
   localparam logic [MODE_W-1:0]        STENCIL_RESET   = STENCIL_CENTERED;
   localparam logic signed [COEF_W-1:0] COEF_RESET      = 16'sd3277;

   // Step numbers that travel with a word down the pipeline.
   typedef struct packed {
      logic [STEP_W-1:0] step_index;
      logic [STEP_W-1:0] label_step;
   } meta_type;

endpackage

[sv/tfir_cell.sv]
// ----------------------------------------------------------------------------
// Time-axis FIR filter delay-line cell
// Holds one window sample, hands it to the older neighbor on each shift and
// registers the weighted product of the sample it takes in.
// ----------------------------------------------------------------------------
module tfir_cell #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           shift_en,
   input  logic                                           clear,
   input  logic signed [SAMPLE_BITS-1:0]                  shift_in,
   input  logic signed [tfir_pkg::COEF_W-1:0]             coef,
   output logic signed [SAMPLE_BITS-1:0]                  sample_out,
   output logic signed [SAMPLE_BITS+tfir_pkg::COEF_W-1:0] prod_out
);
   import tfir_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + COEF_W;

   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [PROD_W-1:0]      prod_in;

   // A restart empties the window before the new sample shifts in.
   assign sample_in = clear ? '0 : shift_in;
   assign prod_in   = PROD_W'(sample_in) * PROD_W'(coef);

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift_en) begin
         sample_ff <= sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         prod_ff <= prod_in;
      end
   end

   assign sample_out = sample_ff;
   assign prod_out   = prod_ff;

endmodule

[sv/tfir_sum.sv]
// ----------------------------------------------------------------------------
// Time-axis FIR filter sum and output stage
// Adds the tap products, rounds the Q21.14 sum, saturates it and holds the
// finished word in the output register.
// ----------------------------------------------------------------------------
module tfir_sum #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_TAPS    = 5
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  logic signed [SAMPLE_BITS+tfir_pkg::COEF_W-1:0] prod [MAX_TAPS],
   input  tfir_pkg::meta_type                             in_meta,
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output logic signed [SAMPLE_BITS-1:0]                  out_filtered,
   output tfir_pkg::meta_type                             out_meta,
   output logic                                           out_saturated
);
   import tfir_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + COEF_W;
   localparam int SUM_W  = PROD_W + $clog2(MAX_TAPS);
   localparam int R_W    = SUM_W + 1 - FRAC_BITS;
   localparam logic signed [R_W-1:0] R_MAX = R_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [R_W-1:0] R_MIN = -R_MAX - R_W'(1);
   localparam logic signed [SUM_W:0] ROUND_HALF = (SUM_W + 1)'(1 << (FRAC_BITS - 1));

   logic                          sum_valid_ff;
   logic signed [SUM_W-1:0]       sum_ff;
   logic signed [SUM_W-1:0]       sum_in;
   meta_type                      sum_meta_ff;
   logic                          out_en;

   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] filtered_ff;
   logic signed [SAMPLE_BITS-1:0] filtered_in;
   logic                          sat_ff;
   logic                          sat_in;
   meta_type                      rsp_meta_ff;

   logic signed [SUM_W:0]         biased;
   logic signed [R_W-1:0]         rounded;

   assign out_en   = !rsp_valid_ff || out_ready;
   assign in_ready = !sum_valid_ff || out_en;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < MAX_TAPS; i++) begin
         sum_in = sum_in + SUM_W'(prod[i]);
      end
   end

   // Floor after adding one half rounds ties toward plus infinity.
   assign biased  = (SUM_W + 1)'(sum_ff) + ROUND_HALF;
   assign rounded = R_W'(biased >>> FRAC_BITS);

   always_comb begin
      if (rounded > R_MAX) begin
         filtered_in = SAMPLE_BITS'(R_MAX);
         sat_in      = 1'b1;
      end else if (rounded < R_MIN) begin
         filtered_in = SAMPLE_BITS'(R_MIN);
         sat_in      = 1'b1;
      end else begin
         filtered_in = SAMPLE_BITS'(rounded);
         sat_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            sum_valid_ff <= in_valid;
         end
         if (out_en) begin
            rsp_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         sum_ff      <= sum_in;
         sum_meta_ff <= in_meta;
      end
      if (out_en) begin
         filtered_ff <= filtered_in;
         sat_ff      <= sat_in;
         rsp_meta_ff <= sum_meta_ff;
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign out_filtered  = filtered_ff;
   assign out_saturated = sat_ff;
   assign out_meta      = rsp_meta_ff;

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && sat_ff |->
         filtered_ff == SAMPLE_BITS'(R_MAX) || filtered_ff == SAMPLE_BITS'(R_MIN))
      else $error("saturated word not at a range limit");

   a_out_from_sum: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(sum_valid_ff))
      else $error("output word appeared without a sum behind it");

endmodule

[sv/time_axis_fir_filter_top.sv]
// ----------------------------------------------------------------------------
// Time-axis FIR filter
// Valid-only FIR over a sliding window of samples with stencil timestamps.
// ----------------------------------------------------------------------------
// The filter takes one sample word per clock while not stalled and, once the
// window holds as many samples since the last restart as taps in use, gives
// one result word per sample. Each delay-line cell owns one window sample and
// its own multiplier, so all taps multiply in the cycle the sample arrives; a
// result then passes the product, sum and rounded output registers. Stages
// stall independently, so a result waiting at the output stops the input only
// once two more results fill the sum and product stages behind it. The user
// must write configuration only while the filter is idle; nothing enforces it.
module time_axis_fir_filter_top #(
   parameter int MAX_TAPS    = 5,
   parameter int SAMPLE_BITS = 16,
   localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int OUT_DATA_W = ((SAMPLE_BITS + 2 * tfir_pkg::STEP_W + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // Sample words
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [IN_DATA_W-1:0]                req_tdata,   // sample
   input  logic [0:0]                          req_tuser,   // restart
   // Result words
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [OUT_DATA_W-1:0]               rsp_tdata,   // filtered, step_index, label_step
   output logic [0:0]                          rsp_tuser,   // saturated
   // Configuration writes
   input  logic                                csr_we,
   input  logic [tfir_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [tfir_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tfir_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + COEF_W;
   localparam int FILL_W = $clog2(MAX_TAPS + 1);

   logic [TAP_W-1:0]         tap_count_ff;
   logic [MODE_W-1:0]        stencil_ff;
   logic signed [COEF_W-1:0] coef_ff [NUM_COEF];

   logic [FILL_W-1:0]        fill_ff;
   logic [FILL_W-1:0]        fill_in;
   logic [STEP_W-1:0]        count_ff;
   logic [STEP_W-1:0]        count_base;
   logic                     prod_valid_ff;
   meta_type                 prod_meta_ff;
   meta_type                 meta_in;

   logic                     accept;
   logic                     restart;
   logic                     produce;
   logic                     sum_ready;
   logic [FILL_W-1:0]        taps;
   logic [STEP_W-1:0]        offset;

   logic signed [SAMPLE_BITS-1:0] sample;
   logic signed [SAMPLE_BITS-1:0] cell_sample [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] cell_in     [MAX_TAPS];
   logic signed [COEF_W-1:0]      cell_coef   [MAX_TAPS];
   logic signed [PROD_W-1:0]      cell_prod   [MAX_TAPS];

   logic signed [SAMPLE_BITS-1:0] rsp_filtered;
   meta_type                      rsp_meta;
   logic                          rsp_sat;

   assign sample     = SAMPLE_BITS'(req_tdata[SAMPLE_BITS-1:0]);
   assign restart    = req_tuser[0];
   assign req_tready = !prod_valid_ff || sum_ready;
   assign accept     = req_tvalid && req_tready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
         stencil_ff   <= STENCIL_RESET;
         for (int j = 0; j < NUM_COEF; j++) begin
            coef_ff[j] <= COEF_RESET;
         end
      end else if (csr_we) begin
         if (csr_addr == CSR_TAP_COUNT) begin
            tap_count_ff <= csr_wdata[TAP_W-1:0];
         end
         if (csr_addr == CSR_STENCIL_MODE) begin
            stencil_ff <= csr_wdata[MODE_W-1:0];
         end
         for (int j = 0; j < NUM_COEF; j++) begin
            if (csr_addr == CSR_ADDR_W'(CSR_COEF_BASE + j)) begin
               coef_ff[j] <= COEF_W'(csr_wdata);
            end
         end
      end
   end

   // Taps in use, with out-of-range counts clamped.
   always_comb begin
      if (int'(tap_count_ff) < 2) begin
         taps = FILL_W'(2);
      end else if (int'(tap_count_ff) > MAX_TAPS) begin
         taps = FILL_W'(MAX_TAPS);
      end else begin
         taps = FILL_W'(tap_count_ff);
      end
   end

   always_comb begin
      case (stencil_ff)
         STENCIL_BACKWARD: offset = STEP_W'(taps) - STEP_W'(1);
         STENCIL_FORWARD:  offset = '0;
         default:          offset = STEP_W'(taps >> 1);
      endcase
   end

   // The newest taps sit at the young end of the chain; the oldest sample
   // of the window meets coef_0.
   always_comb begin
      for (int k = 0; k < MAX_TAPS; k++) begin
         cell_coef[k] = '0;
         for (int j = 0; j < NUM_COEF; j++) begin
            if (j < MAX_TAPS && k + int'(taps) == MAX_TAPS + j) begin
               cell_coef[k] = coef_ff[j];
            end
         end
      end
   end

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      if (k == MAX_TAPS - 1) begin : g_young
         assign cell_in[k] = sample;
      end else begin : g_old
         assign cell_in[k] = cell_sample[k+1];
      end

      tfir_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (accept),
         .clear      (restart && (k != MAX_TAPS - 1)),
         .shift_in   (cell_in[k]),
         .coef       (cell_coef[k]),
         .sample_out (cell_sample[k]),
         .prod_out   (cell_prod[k])
      );
   end

   always_comb begin
      if (restart) begin
         fill_in    = FILL_W'(1);
         count_base = '0;
      end else begin
         fill_in    = (int'(fill_ff) < MAX_TAPS) ? fill_ff + FILL_W'(1) : fill_ff;
         count_base = count_ff;
      end
   end

   assign produce            = fill_in >= taps;
   assign meta_in.step_index = count_base;
   assign meta_in.label_step = count_base + offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         count_ff      <= '0;
         prod_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff  <= fill_in;
            count_ff <= produce ? count_base + STEP_W'(1) : count_base;
         end
         if (req_tready) begin
            prod_valid_ff <= accept && produce;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_meta_ff <= meta_in;
      end
   end

   tfir_sum #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_TAPS    (MAX_TAPS)
   ) u_sum (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (prod_valid_ff),
      .in_ready      (sum_ready),
      .prod          (cell_prod),
      .in_meta       (prod_meta_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_filtered  (rsp_filtered),
      .out_meta      (rsp_meta),
      .out_saturated (rsp_sat)
   );

   assign rsp_tdata = OUT_DATA_W'({rsp_meta.label_step, rsp_meta.step_index, rsp_filtered});
   assign rsp_tuser = rsp_sat;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) <= MAX_TAPS)
      else $error("fill count beyond window length");

   a_restart_fill: assert property (@(posedge clock) disable iff (reset)
      accept && restart |=> fill_ff == FILL_W'(1))
      else $error("restart did not leave one sample in the window");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept && !restart && produce |=> count_ff == $past(count_ff) + STEP_W'(1))
      else $error("output counter did not advance with a result");

endmodule

[sim/fir_check_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FIR filter checking package
// Word types and a scoreboard that mirrors the filter's window and registers
// to predict each result word and compare it with what the filter gives.
// ----------------------------------------------------------------------------
package fir_check_pkg;

   import tfir_pkg::*;

   localparam int WINDOW_LEN   = 5;
   localparam int REPORT_LIMIT = 10;

   localparam logic [MODE_W-1:0] STENCIL_UNUSED = 2'd3;

   typedef logic signed [15:0] sample_type;
   typedef logic [CSR_DATA_W-1:0] coef_set_type [NUM_COEF];

   // Same order as the result bus, most significant field first.
   typedef struct packed {
      logic                     saturated;
      logic [STEP_W-1:0]        label_step;
      logic [STEP_W-1:0]        step_index;
      logic signed [COEF_W-1:0] filtered;
   } fir_word_type;

   class fir_scoreboard;
      logic [TAP_W-1:0]         tap_reg;
      logic [MODE_W-1:0]        mode_reg;
      logic signed [COEF_W-1:0] coef_reg [NUM_COEF];
      sample_type               history [WINDOW_LEN];
      int unsigned              held;
      logic [STEP_W-1:0]        step_count;
      fir_word_type             outputs_due [$];
      int                       errors;
      int                       checked;

      function new();
         tap_reg    = TAP_COUNT_RESET;
         mode_reg   = STENCIL_RESET;
         foreach (coef_reg[i]) coef_reg[i] = COEF_RESET;
         foreach (history[i]) history[i] = '0;
         held       = 0;
         step_count = '0;
         errors     = 0;
         checked    = 0;
      endfunction

      function void write_reg(int idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_TAP_COUNT) begin
            tap_reg = value[TAP_W-1:0];
         end else if (idx == CSR_STENCIL_MODE) begin
            mode_reg = value[MODE_W-1:0];
         end else if (idx >= CSR_COEF_BASE && idx < CSR_COEF_BASE + NUM_COEF) begin
            coef_reg[idx - CSR_COEF_BASE] = value;
         end
      endfunction

      // Shift one sample into the window and queue the result it produces.
      function void filter_sample(sample_type value, logic restart);
         int unsigned  n;
         int unsigned  offset;
         longint       acc;
         longint       rounded;
         fir_word_type word;
         if (restart) begin
            foreach (history[i]) history[i] = '0;
            held       = 0;
            step_count = '0;
         end
         for (int i = 0; i < WINDOW_LEN - 1; i++) history[i] = history[i + 1];
         history[WINDOW_LEN - 1] = value;
         if (held < WINDOW_LEN) held++;
         n = (tap_reg < 2) ? 2 : (tap_reg > WINDOW_LEN) ? WINDOW_LEN : tap_reg;
         if (held < n) return;
         acc = 0;
         for (int i = 0; i < n; i++)
            acc += longint'(coef_reg[i]) * longint'(history[WINDOW_LEN - n + i]);
         // Arithmetic shift gives the floor, so halves round toward plus infinity.
         rounded = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
         word.saturated = 1'b0;
         if (rounded > 32767) begin
            rounded = 32767;
            word.saturated = 1'b1;
         end else if (rounded < -32768) begin
            rounded = -32768;
            word.saturated = 1'b1;
         end
         case (mode_reg)
            STENCIL_BACKWARD: offset = n - 1;
            STENCIL_FORWARD:  offset = 0;
            default:          offset = n / 2;
         endcase
         word.filtered   = rounded[15:0];
         word.step_index = step_count;
         word.label_step = step_count + offset;
         step_count++;
         outputs_due = {outputs_due, word};
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= REPORT_LIMIT) $display("result word %0d: %s", checked, what);
      endfunction

      function void compare_output(fir_word_type got);
         fir_word_type want;
         checked++;
         if (outputs_due.size() == 0) begin
            flag($sformatf("unexpected word, filtered %0d step %0d label %0d sat %0b",
                           got.filtered, got.step_index, got.label_step, got.saturated));
            return;
         end
         want = outputs_due.pop_front();
         if (got.filtered !== want.filtered)
            flag($sformatf("filtered expected %0d, got %0d", want.filtered, got.filtered));
         if (got.step_index !== want.step_index)
            flag($sformatf("step_index expected %0d, got %0d", want.step_index,
                           got.step_index));
         if (got.label_step !== want.label_step)
            flag($sformatf("label_step expected %0d, got %0d", want.label_step,
                           got.label_step));
         if (got.saturated !== want.saturated)
            flag($sformatf("saturated expected %0b, got %0b", want.saturated,
                           got.saturated));
      endfunction
   endclass

endpackage

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Time-axis FIR filter testbench
// Directed and random sample streams under several register settings, with
// random stalls on both sides; every result word is checked against a
// scoreboard that predicts the window sum, saturation and step numbers.
// ----------------------------------------------------------------------------
module tb_top;

   import tfir_pkg::*;
   import fir_check_pkg::*;

   localparam int IN_W            = 16;
   localparam int OUT_W           = 80;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_CYCLES     = 64;
   localparam int HOLD_AT         = 30;
   localparam int STALL_LIMIT     = 2000;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 136;

   localparam sample_type SAMPLE_MAX = 16'sh7FFF;
   localparam sample_type SAMPLE_MIN = 16'sh8000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_W-1:0]       req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_W-1:0]      rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int send_idle_pct = 11;
   int rsp_idle_pct  = 81;
   int rsp_hold_req  = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int stall_cycles  = 0;

   fir_scoreboard fir_sb;

   time_axis_fir_filter_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // sample
      .req_tuser  (req_tuser),   // restart
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // filtered, step_index, label_step
      .rsp_tuser  (rsp_tuser),   // saturated
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: random stalls, plus a long hold each time one is requested.
   always @(negedge clock) begin
      if (hold_seen != rsp_hold_req) begin
         hold_seen  <= rsp_hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Results are checked before the sample of the same edge is taken in;
   // a result never belongs to a sample accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            fir_sb.compare_output(fir_word_type'({rsp_tuser[0], rsp_tdata}));
         if (req_tvalid && req_tready)
            fir_sb.filter_sample(sample_type'(req_tdata), req_tuser[0]);
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Called and left at a falling edge; returns once the word is taken.
   task automatic send_sample(input sample_type value, input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= value;
      req_tuser[0] <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Samples that cause no result can still be in flight once the queue is
   // empty, so a drain wait follows before the filter counts as idle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (fir_sb.outputs_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] taps,
                                 input logic [CSR_DATA_W-1:0] mode,
                                 input coef_set_type coefs);
      logic [CSR_DATA_W-1:0] vals [CSR_COEF_BASE + NUM_COEF];
      vals[CSR_TAP_COUNT]    = taps;
      vals[CSR_STENCIL_MODE] = mode;
      for (int k = 0; k < NUM_COEF; k++) vals[CSR_COEF_BASE + k] = coefs[k];
      wait_drained();
      for (int i = 0; i < CSR_COEF_BASE + NUM_COEF; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= CSR_ADDR_W'(i);
         csr_wdata <= vals[i];
         fir_sb.write_reg(i, vals[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic sample_type random_sample();
      case ($urandom_range(7))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return sample_type'($urandom_range(64)) - 16'sd32;
         default: return sample_type'($urandom());
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_coef();
      case ($urandom_range(7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'd16384;   // unity gain in Q2.14
         3:       return 16'h0000;
         4:       return CSR_DATA_W'($urandom_range(8192)) - 16'd4096;
         default: return CSR_DATA_W'($urandom());
      endcase
   endfunction

   initial begin
      coef_set_type          coefs;
      logic [CSR_DATA_W-1:0] taps;
      logic [CSR_DATA_W-1:0] mode;
      int                    restart_pct;

      fir_sb = new();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // All-max weights: the first full window clips high, windows mostly of the
      // negative run clip low; the first four samples from restart give nothing.
      apply_settings(16'd5, {14'd0, STENCIL_BACKWARD},
                     '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
      send_sample(SAMPLE_MAX, 1'b1);
      repeat (4) send_sample(SAMPLE_MAX, 1'b0);
      repeat (5) send_sample(SAMPLE_MIN, 1'b0);

      // Tap count above range acts as five, the spare mode code as centered.
      apply_settings(16'hFFFF, {14'h3FFF, STENCIL_UNUSED},
                     '{16'h8000, 16'h0000, 16'h7FFF, 16'd16384, 16'hFFFF});
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);

      // Tap count below range acts as two.
      apply_settings(16'd0, {14'd0, STENCIL_FORWARD},
                     '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);

      // Even tap count centered, with sums that land exactly on a half.
      apply_settings(16'd4, {14'd0, STENCIL_CENTERED},
                     '{16'd8192, 16'h0000, 16'h0000, 16'hE000, 16'h7FFF});
      send_sample(-16'sd1, 1'b1);
      send_sample(16'sd5, 1'b0);
      send_sample(16'sd7, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd1, 1'b0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase / 4)
            0: begin
               send_idle_pct <= 11;
               rsp_idle_pct  <= 81;
            end
            1: begin
               send_idle_pct <= 81;
               rsp_idle_pct  <= 11;
            end
            default: begin
               send_idle_pct <= 0;
               rsp_idle_pct  <= 0;
            end
         endcase
         for (int k = 0; k < NUM_COEF; k++) coefs[k] = random_coef();
         // Upper register bits carry junk; only the low bits take effect.
         taps = (phase == 0) ? 16'd2 : (phase == 1) ? 16'd5 : CSR_DATA_W'($urandom());
         mode = CSR_DATA_W'($urandom());
         // Every fifth phase restarts often to keep the window from filling.
         restart_pct = (phase % 5 == 4) ? 35 : 2;
         apply_settings(taps, mode, coefs);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (k == HOLD_AT) rsp_hold_req <= rsp_hold_req + 1;
            send_sample(random_sample(), $urandom_range(99) < restart_pct);
         end
      end

      wait_drained();
      if (fir_sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
